// ===== hdl/utf8_to_utf16_decoder_top_defines.svh =====
// Assertion macros shared by the UTF-8 to UTF-16 decoder RTL.
`ifndef UTF8_TO_UTF16_DECODER_TOP_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Implication or plain property, checked on clk while out of reset.
`define U8U16_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition that must never be seen on a clock edge out of reset.
`define U8U16_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define U8U16_ASSERT(lbl, prop, msg)
`define U8U16_NEVER(lbl, cond, msg)
`endif

`endif

// ===== hdl/u8u16_pkg.sv =====
// Types and constants of the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

	localparam logic [20:0] MAX_CODE_POINT = 21'h10FFFF;
	localparam logic [20:0] BMP_MAX        = 21'h00FFFF;
	localparam logic [20:0] SUPP_BASE      = 21'h010000;
	localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
	localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
	localparam logic [1:0]  CONT_MARK      = 2'b10;
	localparam logic [15:0] CAP_RESET      = 16'd1024;

	// result queue geometry
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
	localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [15:0] unit;
		logic        term;
		logic        stopped;
	} res_t;

	// results produced by one byte: count 0..2, first then second
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	// queue status seen by the input stage
	typedef struct packed {
		logic          room2;
		logic [Q_CW-1:0] count;
	} qstat_t;

endpackage

// ===== hdl/u8u16_core.sv =====
// Per-string decode state and the byte-to-unit conversion logic.
module u8u16_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [7:0]           byte_s1,
	input  logic [15:0]          cap,
	output u8u16_pkg::push_t     push
);

	logic [20:0] acc_q, acc_d;
	logic [1:0]  pend_q, pend_d;
	logic [15:0] units_q, units_d;
	logic        halted_q, halted_d;

	logic        emit_req;
	logic [20:0] cp;
	logic [20:0] acc_step;
	logic [1:0]  pend_dec;
	logic [20:0] cp_off;
	logic [16:0] units_p1, units_p2;

	assign acc_step = {acc_q[14:0], byte_s1[5:0]};
	assign pend_dec = pend_q - 2'd1;
	assign cp_off   = cp - u8u16_pkg::SUPP_BASE;
	assign units_p1 = {1'b0, units_q} + 17'd1;
	assign units_p2 = {1'b0, units_q} + 17'd2;

	// byte classification and sequence assembly
	always_comb begin
		acc_d    = acc_q;
		pend_d   = pend_q;
		halted_d = halted_q;
		emit_req = 1'b0;
		cp       = '0;
		if (byte_s1 != 8'd0 && !halted_q) begin
			if (pend_q != 2'd0) begin
				if (byte_s1[7:6] != u8u16_pkg::CONT_MARK) begin
					halted_d = 1'b1;
					pend_d   = 2'd0;
				end else begin
					acc_d  = acc_step;
					pend_d = pend_dec;
					if (pend_dec == 2'd0) begin
						emit_req = 1'b1;
						cp       = acc_step;
					end
				end
			end else if (!byte_s1[7]) begin
				emit_req = 1'b1;
				cp       = {13'd0, byte_s1};
			end else if (byte_s1[7:5] == 3'b110) begin
				acc_d  = {16'd0, byte_s1[4:0]};
				pend_d = 2'd1;
			end else if (byte_s1[7:4] == 4'b1110) begin
				acc_d  = {17'd0, byte_s1[3:0]};
				pend_d = 2'd2;
			end else if (byte_s1[7:3] == 5'b11110) begin
				acc_d  = {18'd0, byte_s1[2:0]};
				pend_d = 2'd3;
			end else begin
				halted_d = 1'b1;
			end
		end
	end

	// unit emission, capacity check and terminator
	always_comb begin
		push    = '0;
		units_d = units_q;
		if (byte_s1 == 8'd0) begin
			push.n          = 2'd1;
			push.r0.term    = 1'b1;
			push.r0.stopped = halted_q || (pend_q != 2'd0);
		end else if (emit_req) begin
			if (units_p1 >= {1'b0, cap}) begin
				// no room before the terminator slot
			end else if (cp > u8u16_pkg::BMP_MAX) begin
				if (units_p2 < {1'b0, cap} && cp <= u8u16_pkg::MAX_CODE_POINT) begin
					push.n       = 2'd2;
					push.r0.unit = u8u16_pkg::HIGH_SURR_BASE + {6'd0, cp_off[19:10]};
					push.r1.unit = u8u16_pkg::LOW_SURR_BASE + {6'd0, cp[9:0]};
					units_d      = units_p2[15:0];
				end
			end else begin
				push.n       = 2'd1;
				push.r0.unit = cp[15:0];
				units_d      = units_p1[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			pend_q   <= '0;
			units_q  <= '0;
			halted_q <= 1'b0;
		end else if (fire) begin
			if (byte_s1 == 8'd0) begin
				acc_q    <= '0;
				pend_q   <= '0;
				units_q  <= '0;
				halted_q <= 1'b0;
			end else begin
				acc_q    <= acc_d;
				pend_q   <= pend_d;
				units_q  <= units_d;
				// a code point that was due but not emitted stops the string
				halted_q <= halted_d || (emit_req && push.n == 2'd0);
			end
		end
	end

endmodule

// ===== hdl/u8u16_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one.
module u8u16_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  u8u16_pkg::push_t     push,
	input  logic                 pop,
	output logic                 nonempty,
	output u8u16_pkg::res_t      head,
	output u8u16_pkg::qstat_t    stat
);

	localparam int unsigned AW = u8u16_pkg::Q_AW;
	localparam int unsigned CW = u8u16_pkg::Q_CW;

	u8u16_pkg::res_t mem_q [u8u16_pkg::Q_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic [1:0]    n_in;
	logic [AW-1:0] wr_p1;

	assign n_in       = fire ? push.n : 2'd0;
	assign wr_p1      = wr_q + AW'(1);
	assign nonempty   = (count_q != '0);
	assign head       = mem_q[rd_q];
	assign stat.count = count_q;
	assign stat.room2 = (count_q <= CW'(u8u16_pkg::Q_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (n_in != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (n_in == 2'd2) begin
			mem_q[wr_p1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + AW'(n_in);
			rd_q    <= rd_q + AW'(pop);
			count_q <= count_q + CW'(n_in) - CW'(pop);
		end
	end

endmodule

// ===== hdl/utf8_to_utf16_decoder_top.sv =====
// Top level of the UTF-8 to UTF-16 decoder: input stage, decoder, result queue.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in      | sink      | in_valid / in_stall  | in_byte[7:0]
//  out     | source    | out_valid / out_stall| out_unit[15:0], is_terminator, stopped_early
//  cfg     | sink      | cfg_valid / cfg_ready| cfg_data[15:0] (out_capacity)
//
// One byte is taken per cycle while the queue has room for a pair. A byte is
// held in the input register; its results enter the queue when it moves on and
// the first can then leave from the queue head. A four-byte sequence yields two
// units, pushed together, so the rate is one item per cycle as long as the
// 4-entry result queue has two free slots.
// Reset (arst_n low) clears the string state, empties the queue and loads
// out_capacity with 1024. No clearing pass is needed.
// out_stall only backs up the queue; in_stall rises once the queue cannot
// take another two results and a byte waits in the input register.
`include "utf8_to_utf16_decoder_top_defines.svh"

module utf8_to_utf16_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	// unit output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] out_unit,
	output logic        is_terminator,
	output logic        stopped_early,
	// capacity register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic [15:0]       cap_q;
	logic              fire;
	logic              in_take;
	logic              pop;
	u8u16_pkg::push_t  push;
	u8u16_pkg::res_t   head;
	u8u16_pkg::qstat_t qstat;

	// the byte in the input register moves on when the queue has room for a pair
	assign fire     = valid_s1 && qstat.room2;
	assign in_stall = valid_s1 && !qstat.room2;
	assign in_take  = in_valid && !in_stall;
	assign pop      = out_valid && !out_stall;

	// configuration is always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= u8u16_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= in_byte;
		end
	end

	u8u16_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_s1 (byte_s1),
		.cap     (cap_q),
		.push    (push)
	);

	u8u16_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.push     (push),
		.pop      (pop),
		.nonempty (out_valid),
		.head     (head),
		.stat     (qstat)
	);

	assign out_unit      = head.unit;
	assign is_terminator = head.term;
	assign stopped_early = head.stopped;

	// a pair must never be pushed into a queue that cannot hold it
	`U8U16_NEVER(a_queue_overflow, fire && ({1'b0, qstat.count} + {1'b0, push.n} > 4'd4), "result queue overflow")
	// the zero byte always produces exactly one terminator result
	`U8U16_ASSERT(a_zero_term, (fire && byte_s1 == 8'd0) |-> (push.n == 2'd1 && push.r0.term && push.r0.unit == 16'd0), "zero byte did not yield a terminator")
	// data units never carry the stop flag
	`U8U16_NEVER(a_data_stop, out_valid && !is_terminator && stopped_early, "stop flag on a data unit")
	// a stalled input means a byte is held and the queue is short of room
	`U8U16_ASSERT(a_stall_cause, in_stall |-> (valid_s1 && qstat.count > 3'd2), "input stalled without cause")

endmodule
